### hw/rtl/rvm_pkg.sv
`timescale 1ns / 1ps
package rvm_pkg;
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_MIX  = 2'd1;
  localparam logic [1:0] OP_CUR  = 2'd2;

  localparam logic [2:0] REG_S16   = 3'd0;
  localparam logic [2:0] REG_SCH   = 3'd1;
  localparam logic [2:0] REG_OCH   = 3'd2;
  localparam logic [2:0] REG_FRM   = 3'd3;
  localparam logic [2:0] REG_STEP  = 3'd4;
  localparam logic [2:0] REG_LOOP  = 3'd5;
  localparam logic [2:0] REG_GAIN  = 3'd6;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] byte_addr;
    logic [7:0]  byte_value;
    logic [31:0] cursor_value;
    logic signed [15:0] mix_in_left;
    logic signed [15:0] mix_in_right;
  } item_t;

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) return 16'sh7fff;
    if (v < -36'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction
endpackage

### hw/rtl/rvm_ram.sv
`timescale 1ns / 1ps
module rvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/rvm_front.sv
`timescale 1ns / 1ps
module rvm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rvm_pkg::item_t   in_item,
  output logic             q_valid,
  input  logic             q_ready,
  output rvm_pkg::item_t   q_item
);
  import rvm_pkg::*;
  // two-entry queue; unused ops dropped here
  item_t       buf_r [2];
  logic [1:0]  cnt_r, cnt_nxt;
  logic        wp_r, rp_r;
  logic        push, pop, keep;

  assign keep     = (in_item.op == OP_LOAD) || (in_item.op == OP_MIX) ||
                    (in_item.op == OP_CUR);
  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = buf_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= in_item;
    end
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
  end
endmodule

### hw/rtl/rvm_back.sv
`timescale 1ns / 1ps
module rvm_back #(
  parameter int SAMPLE_BYTES = 65536,
  parameter int FRAC_BITS    = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  rvm_pkg::item_t   q_item,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [23:0]      cfg_wdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,
  output logic             out_tuser
);
  import rvm_pkg::*;
  localparam int AW = $clog2(SAMPLE_BYTES);
  localparam int CW = 33;
  localparam int VW = FRAC_BITS + 18;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_WAIT  = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_ADD   = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic        s16_r, loop_r;
  logic [1:0]  sch_r, och_r;
  logic [16:0] frm_r;
  logic [23:0] step_r;
  logic signed [15:0] gain_r;

  logic [3:0]  st_r;
  logic [CW-1:0] cur_r;
  logic        ch_r;     // output channel
  logic [1:0]  k_r;      // byte index: frame0 lo, frame0 hi, frame1 lo, frame1 hi
  logic [7:0]  lo_r;
  logic signed [15:0] s0_r, s1_r;
  logic signed [VW-1:0] v_r;
  logic signed [VW+15:0] p_r;
  logic signed [15:0] o0_r, o1_r;
  logic        end_r;

  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic          we;

  rvm_ram #(.WIDTH(8), .DEPTH(SAMPLE_BYTES)) u_ram (
    .clk(clk), .we(we), .waddr(AW'(q_item.byte_addr)), .wdata(q_item.byte_value),
    .raddr(raddr), .rdata(rdata)
  );

  logic idle;
  assign idle    = (st_r == S_IDLE);
  assign q_ready = idle;
  assign we      = idle && q_valid && (q_item.op == OP_LOAD);

  logic [CW-FRAC_BITS-1:0] i0;
  logic [FRAC_BITS-1:0]    frac;
  logic [CW-1:0]           len;
  logic                    oob;
  assign i0   = cur_r[CW-1:FRAC_BITS];
  assign frac = cur_r[FRAC_BITS-1:0];
  assign len  = CW'(frm_r) << FRAC_BITS;
  assign oob  = (CW'(i0) + CW'(1)) >= CW'(frm_r);

  logic [1:0]  nch;
  logic        sc;
  logic [CW+3:0] off;
  assign nch = (och_r == 2'd3) ? 2'd2 : och_r;
  // channel 1 falls back to source channel 0 on a mono source
  assign sc  = ch_r && (sch_r != 2'd1);
  always_comb begin
    logic [CW+3:0] idx, fidx;
    idx  = (CW+4)'(i0) + (CW+4)'(k_r[1]);
    fidx = (sch_r[0] ? idx : '0) + (sch_r[1] ? (idx << 1) : '0);
    if (s16_r) off = (fidx << 1) + (CW+4)'({sc, k_r[0]});
    else       off = fidx + (CW+4)'(sc);
  end
  assign raddr = AW'(off);

  logic signed [15:0] smp;
  assign smp = s16_r ? {rdata, lo_r} : {rdata - 8'd128, 8'd0};

  logic signed [35:0] scaled;
  always_comb begin
    logic signed [VW+15:0] t;
    t = p_r;
    if (t < 0) t = t + ((VW+16)'(1) << (FRAC_BITS + 12)) - 1;
    scaled = 36'(t >>> (FRAC_BITS + 12));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cur_r  <= '0;
      s16_r  <= 1'b1;
      sch_r  <= 2'd1;
      och_r  <= 2'd2;
      frm_r  <= '0;
      step_r <= 24'd65536;
      loop_r <= 1'b0;
      gain_r <= 16'sd4096;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_S16:  s16_r  <= cfg_wdata[0];
          REG_SCH:  sch_r  <= cfg_wdata[1:0];
          REG_OCH:  och_r  <= cfg_wdata[1:0];
          REG_FRM:  frm_r  <= cfg_wdata[16:0];
          REG_STEP: step_r <= cfg_wdata;
          REG_LOOP: loop_r <= cfg_wdata[0];
          REG_GAIN: gain_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.op == OP_CUR) cur_r <= CW'(q_item.cursor_value);
            if (q_item.op == OP_MIX) begin
              o0_r <= q_item.mix_in_left;
              o1_r <= q_item.mix_in_right;
              st_r <= S_CHK;
            end
          end
        end
        S_CHK: begin
          ch_r <= 1'b0;
          k_r  <= 2'd0;
          end_r <= 1'b1;
          if (frm_r == 17'd0 || sch_r == 2'd0 || step_r == 24'd0) st_r <= S_OUT;
          else if (oob) begin
            if (!loop_r) st_r <= S_OUT;
            else begin
              cur_r <= (cur_r >= len) ? cur_r - len : '0;
              st_r  <= S_ACC; // recheck via ACC
            end
          end else if (nch == 2'd0) begin
            end_r <= 1'b0;
            cur_r <= cur_r + CW'(step_r);
            st_r  <= S_OUT;
          end else st_r <= S_RD;
        end
        S_ACC: begin
          // after loop wrap
          if (oob) st_r <= S_OUT;
          else if (nch == 2'd0) begin
            end_r <= 1'b0;
            cur_r <= cur_r + CW'(step_r);
            st_r  <= S_OUT;
          end else st_r <= S_RD;
        end
        S_RD: st_r <= S_WAIT;
        S_WAIT: begin
          lo_r <= rdata;
          if (s16_r && !k_r[0]) begin
            k_r  <= k_r + 2'd1;
            st_r <= S_RD;
          end else begin
            if (!k_r[1]) begin
              s0_r <= smp;
              k_r  <= 2'd2;
              st_r <= S_RD;
            end else begin
              s1_r <= smp;
              st_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          v_r  <= VW'(s0_r) * $signed({1'b0, (FRAC_BITS+1)'((1 << FRAC_BITS)) - (FRAC_BITS+1)'(frac)})
                + VW'(s1_r) * $signed({1'b0, frac});
          st_r <= S_ADD;
          k_r  <= 2'd0;
        end
        S_ADD: begin
          if (!k_r[0]) begin
            p_r <= v_r * gain_r;
            k_r <= 2'd1;
          end else begin
            if (!ch_r) o0_r <= sat16(36'(o0_r) + scaled);
            else       o1_r <= sat16(36'(o1_r) + scaled);
            k_r <= 2'd0;
            if (!ch_r && nch == 2'd2) begin
              ch_r <= 1'b1;
              st_r <= S_RD;
            end else begin
              end_r <= 1'b0;
              cur_r <= cur_r + CW'(step_r);
              st_r  <= S_OUT;
            end
          end
        end
        S_OUT: if (out_tready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = {o1_r, o0_r};
  assign out_tuser  = end_r;
endmodule

### hw/rtl/resampling_voice_mixer_unit.sv
`timescale 1ns / 1ps
// Resampling voice mixer.
// in_ carries requests: op 0 writes one byte into the sample store,
// op 1 mixes one output frame, op 2 sets the 16.16 playback cursor.
// Only a mix request yields a result on out_: the two mixed samples in
// tdata and the source-ended flag in tuser.
// cfg_ writes a register; write only while idle.
// A two-entry queue separates acceptance from execution.
// Loads and cursor sets are handled in the back end's idle state. A mix that
// passes through or mixes no channel goes from the check state (and the
// recheck state after a loop wrap) straight to output; else, after the checks,
// each channel reads its store bytes (2 bytes at 8 bits, 4 at 16 bits), then
// takes a multiply step and two add steps, before the result is presented.
// One mix is in the back end at a time.
// Reset clears the cursor and loads register defaults; store contents are
// undefined until written.
// A stalled out_tready holds the result; the queue keeps accepting until full.
module resampling_voice_mixer_unit #(
  parameter int SAMPLE_BYTES = 65536,
  parameter int FRAC_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // op[1:0], byte_addr[17:2], byte_value[25:18], cursor_value[57:26],
  // mix_in_left[73:58], mix_in_right[89:74]
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // mix_out_left[15:0], mix_out_right[31:16]
  output logic [31:0] out_tdata,
  // source_ended
  output logic        out_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);
  import rvm_pkg::*;
  item_t it, qi;
  logic  qv, qr;
  assign it.op           = in_tdata[1:0];
  assign it.byte_addr    = in_tdata[17:2];
  assign it.byte_value   = in_tdata[25:18];
  assign it.cursor_value = in_tdata[57:26];
  assign it.mix_in_left  = in_tdata[73:58];
  assign it.mix_in_right = in_tdata[89:74];

  rvm_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_item(it), .q_valid(qv), .q_ready(qr), .q_item(qi)
  );
  rvm_back #(.SAMPLE_BYTES(SAMPLE_BYTES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(qv), .q_ready(qr), .q_item(qi),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );
  logic unused;
  assign unused = ^in_tdata[95:90];
endmodule

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rvm_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;

  class mix_scoreboard;
    logic [7:0] store [int];
    logic [32:0] cursor;
    logic s16;
    logic [1:0] sch, och;
    logic [16:0] frames;
    logic [23:0] step;
    logic loop_en;
    logic signed [15:0] gain;
    logic [32:0] exp_q[$];
    int errors;

    function void init();
      cursor = '0; s16 = 1; sch = 1; och = 2; frames = 0;
      step = 24'd65536; loop_en = 0; gain = 16'sd4096;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] a, logic [23:0] d);
      case (a)
        REG_S16:  s16 = d[0];
        REG_SCH:  sch = d[1:0];
        REG_OCH:  och = d[1:0];
        REG_FRM:  frames = {1'b0, d[15:0]} | (d[16] ? 17'h10000 : 17'h0);
        REG_STEP: step = d;
        REG_LOOP: loop_en = d[0];
        REG_GAIN: gain = d[15:0];
        default: ;
      endcase
    endfunction

    function longint fetch(longint idx, int ch);
      longint sc, bps, off;
      logic [7:0] lo, hi;
      sc = (ch < sch) ? ch : 0;
      bps = s16 ? 2 : 1;
      off = idx * bps * sch + sc * bps;
      lo = store.exists(int'(off % 65536)) ? store[int'(off % 65536)] : 8'h0;
      if (!s16) return (longint'(lo) - 128) * 256;
      hi = store.exists(int'((off + 1) % 65536)) ? store[int'((off + 1) % 65536)] : 8'h0;
      return longint'($signed({hi, lo}));
    endfunction

    function void note_request(item_t it);
      logic signed [15:0] io[2];
      longint i0, frac, v, sc, len, r;
      int nch;
      logic ended;
      case (it.op)
        OP_LOAD: begin store[int'(it.byte_addr)] = it.byte_value; return; end
        OP_CUR: begin cursor = {1'b0, it.cursor_value}; return; end
        OP_MIX: ;
        default: return;
      endcase
      io[0] = it.mix_in_left; io[1] = it.mix_in_right;
      ended = 1;
      if (frames != 0 && sch != 0 && step != 0) begin
        i0 = longint'(cursor >> 16);
        if (i0 + 1 >= frames && loop_en) begin
          len = longint'(frames) << 16;
          cursor = (longint'(cursor) >= len) ? 33'(longint'(cursor) - len) : '0;
          i0 = longint'(cursor >> 16);
        end
        if (i0 + 1 < frames) begin
          frac = longint'(cursor[15:0]);
          nch = (och > 2) ? 2 : och;
          for (int c = 0; c < nch; c++) begin
            v = fetch(i0, c) * (65536 - frac) + fetch(i0 + 1, c) * frac;
            sc = (v * longint'(gain)) / (longint'(1) << 28);
            r = longint'(io[c]) + sc;
            io[c] = (r > 32767) ? 16'sh7fff : (r < -32768) ? 16'sh8000 : 16'(r);
          end
          cursor = cursor + 33'(step);
          ended = 0;
        end
      end
      exp_q.push_back({ended, io[1], io[0]});
    endfunction

    function void check_result(logic [31:0] d, logic u);
      logic [32:0] e;
      if (exp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h/%b", d, u);
        return;
      end
      e = exp_q.pop_front();
      if (e[15:0] !== d[15:0] || e[31:16] !== d[31:16] || e[32] !== u) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp L=%h R=%h end=%b got L=%h R=%h end=%b",
                   e[15:0], e[31:16], e[32], d[15:0], d[31:16], u);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready;
  logic [95:0] in_tdata = '0;
  logic out_tvalid, out_tready = 0;
  logic [31:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 0;
  logic [2:0] cfg_addr = '0;
  logic [23:0] cfg_wdata = '0;
  bit calm = 0;
  mix_scoreboard sb = new();

  always #2 clk = ~clk;

  resampling_voice_mixer_unit DUT (.*);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    out_tready <= calm || ($urandom_range(99) >= 24);
  end

  function automatic logic [95:0] pack(item_t it);
    return {6'b0, it.mix_in_right, it.mix_in_left, it.cursor_value,
            it.byte_value, it.byte_addr, it.op};
  endfunction

  task automatic send(item_t it);
    while (!calm && $urandom_range(99) < 24) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1; in_tdata <= pack(it);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(it);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.exp_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] a, logic [23:0] d);
    cfg_we <= 1; cfg_addr <= a; cfg_wdata <= d;
    @(posedge clk);
    sb.set_reg(a, d);
  endtask

  function automatic item_t mk(logic [1:0] op);
    item_t it;
    it = 90'({$urandom, $urandom, $urandom});
    it.op = op;
    return it;
  endfunction

  task automatic load_source(int nbytes);
    item_t it;
    for (int a = 0; a < nbytes; a++) begin
      it = mk(OP_LOAD); it.byte_addr = 16'(a); send(it);
    end
  endtask

  task automatic phase(logic s16, int sch, int och, int frm, int stp, logic lp,
                       int g, int nmix);
    item_t it;
    int nb;
    drain();
    write_reg(REG_S16, 24'(s16)); write_reg(REG_SCH, 24'(sch));
    write_reg(REG_OCH, 24'(och)); write_reg(REG_FRM, 24'(frm));
    write_reg(REG_STEP, 24'(stp)); write_reg(REG_LOOP, 24'(lp));
    write_reg(REG_GAIN, 24'(g & 16'hffff));
    cfg_we <= 0;
    nb = (frm == 0 ? 4 : frm) * (s16 ? 2 : 1) * (sch == 0 ? 1 : sch);
    if (nb > 65536) nb = 65536;
    load_source(nb);
    it = mk(OP_CUR); it.cursor_value = '0; send(it);
    for (int k = 0; k < nmix; k++) begin
      case ($urandom_range(19))
        0: begin
          it = mk(OP_CUR);
          it.cursor_value = (frm == 0) ? $urandom : $urandom_range(frm * 65536 + 131072);
          send(it);
        end
        1: send(mk(OP_NOP));
        2: begin
          it = mk(OP_LOAD); it.byte_addr = 16'($urandom_range(nb - 1)); send(it);
        end
        default: send(mk(OP_MIX));
      endcase
    end
  endtask

  initial begin
    item_t it;
    sb.init();
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: reset defaults, no source
    it = mk(OP_MIX); it.mix_in_left = 16'sh7fff; it.mix_in_right = 16'sh8000; send(it);
    send(mk(OP_NOP));
    // wrapping and full-range extremes
    phase(1, 2, 2, 8, 24'hffffff, 1, 32767, 6);
    phase(0, 1, 1, 6, 24'd1, 0, -32768, 6);
    phase(1, 1, 3, 4, 24'd65536, 0, 4096, 8);
    phase(0, 2, 0, 4, 24'd30000, 1, 4096, 4);
    phase(1, 0, 2, 4, 24'd0, 1, 100, 4);
    it = mk(OP_CUR); it.cursor_value = 32'hffffffff; send(it);
    send(mk(OP_MIX));
    calm = 1;
    phase(1, 2, 2, 40, 24'd70000, 1, -4096, 120);
    calm = 0;
    drain();
    phase(0, 2, 2, 40, 24'd20000, 1, 8192, 180);
    phase(1, 1, 2, 30, 24'd150000, 0, -20000, 150);
    phase(0, 1, 2, 50, $urandom_range(24'hffffff), 1, 32767, 150);
    phase(1, 2, 1, 20, 24'd65536, 1, 12345, 150);
    phase(0, 2, 2, 40, 24'h800000, 1, -32768, 20);
    drain();
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
